FILE: src/gmra_pkg.sv
// shared constants, types and command/status structs of the row assigner
package gmra_pkg;

    // default for the number of rows that storage is built for
    localparam int ROWS_MAX_DEF = 8;

    // field widths
    localparam int ITEM_W   = 12;
    localparam int ROW_W    = 16;
    localparam int CHOICE_W = 3;
    localparam int CNT_W    = 4;
    localparam int GAP_W    = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAP       = 2'd1;

    // register reset values
    localparam logic [CNT_W-1:0] ROW_COUNT_RST = 4'd1;
    localparam logic [GAP_W-1:0] GAP_RST       = 8'd0;

    // saturation limit of a row width
    localparam logic [ROW_W-1:0] ROW_SAT = 16'hFFFF;

    // commands from controller to datapath
    typedef struct packed {
        logic load;    // transaction accepted, latch item and read row 0
        logic issue;   // read the next row
        logic cmp;     // fold the row read last cycle into min and max
        logic update;  // write the chosen row and load the result register
    } gmra_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic final_read;  // the row read now is the last row in use
        logic out_space;   // result register can take a new result
    } gmra_sts_t;

endpackage

FILE: src/gmra_ram.sv
// generic single write port, single read port ram with registered read
module gmra_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 8,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: src/gmra_ctrl.sv
// controller state machine: accept, row scan, drain, update
module gmra_ctrl import gmra_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    input  gmra_sts_t sts,
    output gmra_cmd_t cmd
);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_SCAN   = 4'b0010,
        ST_DRAIN  = 4'b0100,
        ST_UPDATE = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_stall = (state_reg != ST_IDLE);

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = sts.final_read ? ST_DRAIN : ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                cmd.issue = 1'b1;
                cmd.cmp   = 1'b1;
                if (sts.final_read)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                cmd.cmp    = 1'b1;
                state_next = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                if (sts.out_space)
                begin
                    cmd.update = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

FILE: src/gmra_dpath.sv
// datapath: configuration, row width store, min/max scan, result register
module gmra_dpath import gmra_pkg::*; #(
    parameter int ROWS_MAX = ROWS_MAX_DEF,
    localparam int IDX_W = (ROWS_MAX > 1) ? $clog2(ROWS_MAX) : 1
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic [ITEM_W-1:0]     item_width,
    input  logic                  is_last,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [CHOICE_W-1:0]   row_choice,
    output logic [ROW_W-1:0]      widest_row,
    output logic                  done_res,
    input  gmra_cmd_t             cmd,
    output gmra_sts_t             sts
);

    // configuration
    logic [CNT_W-1:0] row_count_reg;
    logic [GAP_W-1:0] gap_reg;
    logic             cfg_hit;

    // item and scan state
    logic [ITEM_W-1:0] width_reg;
    logic              last_reg;
    logic [IDX_W-1:0]  idx_reg;
    logic [IDX_W-1:0]  rd_addr;
    logic [IDX_W-1:0]  rd_idx_reg;
    logic              rd_vld_reg;
    logic [IDX_W-1:0]  n_m1;
    logic [7:0]        rc_ext;
    logic [7:0]        n_m1_ext;
    logic [ROW_W-1:0]  rd_data;
    logic [ROW_W-1:0]  row_val;
    logic              have_min_reg;
    logic [ROW_W-1:0]  min_reg;
    logic [ROW_W-1:0]  max_reg;
    logic [IDX_W-1:0]  pick_reg;

    // row valid bits: a row that is not valid reads as the gap value
    logic [ROWS_MAX-1:0] valid_reg;
    logic [ROWS_MAX-1:0] valid_next;

    // placement
    logic [ROW_W+1:0] sum_full;
    logic [ROW_W-1:0] sum_sat;
    logic [ROW_W-1:0] widest_new;

    // result register
    logic                out_valid_reg;
    logic [CHOICE_W-1:0] row_choice_reg;
    logic [ROW_W-1:0]    widest_reg;
    logic                done_reg;

    assign cfg_hit = cfg_we && ((cfg_index == CFG_ROW_COUNT) || (cfg_index == CFG_GAP));

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_count_reg <= ROW_COUNT_RST;
            gap_reg       <= GAP_RST;
        end
        else if (cfg_we)
        begin
            if (cfg_index == CFG_ROW_COUNT)
            begin
                row_count_reg <= cfg_data[CNT_W-1:0];
            end
            else if (cfg_index == CFG_GAP)
            begin
                gap_reg <= cfg_data[GAP_W-1:0];
            end
        end
    end

    // last row in use, zero means one row, clamped to the storage depth
    always_comb
    begin
        rc_ext = {{(8-CNT_W){1'b0}}, row_count_reg};
        if (rc_ext == 8'd0)
        begin
            n_m1_ext = 8'd0;
        end
        else if (rc_ext > 8'(ROWS_MAX))
        begin
            n_m1_ext = 8'(ROWS_MAX - 1);
        end
        else
        begin
            n_m1_ext = rc_ext - 8'd1;
        end
    end
    assign n_m1 = n_m1_ext[IDX_W-1:0];

    // read address: row 0 on accept, then one row on
    assign rd_addr = cmd.load ? '0 : idx_reg + IDX_W'(1);
    assign sts.final_read = (rd_addr == n_m1);

    // row width store
    gmra_ram #(
        .WIDTH (ROW_W),
        .DEPTH (ROWS_MAX)
    ) u_rows (
        .clk   (clk),
        .we    (cmd.update),
        .waddr (pick_reg),
        .wdata (sum_sat),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    assign row_val = rd_vld_reg ? rd_data : {{(ROW_W-GAP_W){1'b0}}, gap_reg};

    // item latch, read tracking, running min and max
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            have_min_reg <= 1'b0;
            idx_reg      <= '0;
        end
        else
        begin
            if (cmd.load || cmd.issue)
            begin
                idx_reg <= rd_addr;
            end
            if (cmd.load)
            begin
                have_min_reg <= 1'b0;
            end
            else if (cmd.cmp)
            begin
                have_min_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            width_reg <= item_width;
            last_reg  <= is_last;
        end
        if (cmd.load || cmd.issue)
        begin
            rd_idx_reg <= rd_addr;
            rd_vld_reg <= valid_reg[rd_addr];
        end
        if (cmd.cmp)
        begin
            if (!have_min_reg || (row_val < min_reg))
            begin
                min_reg  <= row_val;
                pick_reg <= rd_idx_reg;
            end
            if (!have_min_reg || (row_val > max_reg))
            begin
                max_reg <= row_val;
            end
        end
    end

    // saturating placement sum and new widest row
    assign sum_full = {2'b00, min_reg}
                    + {{(ROW_W+2-ITEM_W){1'b0}}, width_reg}
                    + {{(ROW_W+2-GAP_W){1'b0}}, gap_reg};
    assign sum_sat    = (sum_full > {2'b00, ROW_SAT}) ? ROW_SAT : sum_full[ROW_W-1:0];
    assign widest_new = (sum_sat > max_reg) ? sum_sat : max_reg;

    // valid bits: set on write, all cleared on last item or register write
    always_comb
    begin
        valid_next = valid_reg;
        if (cmd.update)
        begin
            valid_next[pick_reg] = 1'b1;
            if (last_reg)
            begin
                valid_next = '0;
            end
        end
        if (cfg_hit)
        begin
            valid_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // result register, free when empty or taken this cycle
    assign sts.out_space = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.update)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.update)
        begin
            row_choice_reg <= CHOICE_W'(pick_reg);
            widest_reg     <= widest_new;
            done_reg       <= last_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign row_choice = row_choice_reg;
    assign widest_row = widest_reg;
    assign done_res   = done_reg;

endmodule

FILE: src/greedy_min_width_row_assigner_core.sv
// top level of the greedy least-loaded row assigner
//
//  channel | direction | handshake         | payload
//  --------+-----------+-------------------+----------------------------------
//  in      | input     | in_valid/in_stall | item_width, is_last
//  out     | output    | out_valid/out_stall | row_choice, widest_row, done_res
//  cfg     | input     | cfg_we            | cfg_index, cfg_data
//
// a transaction steps through acceptance, row scan, drain and update:
// the cycle of acceptance reads row 0, the scan state reads each further row in use, the
// drain state folds the final read and the update state writes the chosen row and loads the
// result register, after which the block returns to idle and can take the next transaction.
// after reset every row reads as the gap value at once; no clearing pass.
// the result register lets the next transaction be accepted while a result waits;
// a stall on the output holds the block in its update step once that register is full.
module greedy_min_width_row_assigner_core import gmra_pkg::*; #(
    parameter int ROWS_MAX = ROWS_MAX_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [ITEM_W-1:0]     item_width,
    input  logic                  is_last,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [CHOICE_W-1:0]   row_choice,
    output logic [ROW_W-1:0]      widest_row,
    output logic                  done_res
);

    gmra_cmd_t cmd;
    gmra_sts_t sts;

    // controller
    gmra_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    // datapath
    gmra_dpath #(
        .ROWS_MAX (ROWS_MAX)
    ) u_dpath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .item_width (item_width),
        .is_last    (is_last),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .row_choice (row_choice),
        .widest_row (widest_row),
        .done_res   (done_res),
        .cmd        (cmd),
        .sts        (sts)
    );

endmodule

FILE: sim/gmra_checker.sv
// checker for the row assigner: mirrors the row widths and compares every result
`timescale 1ns / 1ps

module gmra_checker import gmra_pkg::*; #(
    parameter int ROWS = ROWS_MAX_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    input  logic                  in_stall,
    input  logic [ITEM_W-1:0]     item_width,
    input  logic                  is_last,
    input  logic                  out_valid,
    input  logic                  out_stall,
    input  logic [CHOICE_W-1:0]   row_choice,
    input  logic [ROW_W-1:0]      widest_row,
    input  logic                  done_res,
    output int                    errors,
    output int                    pending
);

    typedef struct packed {
        logic [CHOICE_W-1:0] row;
        logic [ROW_W-1:0]    widest;
        logic                done;
    } placement_t;

    // mirrored state and registers
    logic [ROW_W-1:0] row_width [ROWS];
    logic [CNT_W-1:0] row_count;
    logic [GAP_W-1:0] gap;
    placement_t       placements [$];

    // every row starts over at the padding
    function automatic void refill_rows();
        for (int i = 0; i < ROWS; i++)
            row_width[i] = gap;
    endfunction

    // least-loaded placement of one item, lowest index wins a tie
    function automatic placement_t place_item(input logic [ITEM_W-1:0] w, input logic last);
        int               n;
        int               pick;
        logic [ROW_W+1:0] sum;
        logic [ROW_W-1:0] top;
        placement_t       res;
        n = (row_count == 0) ? 1 : (row_count > ROWS) ? ROWS : int'(row_count);
        pick = 0;
        for (int j = 1; j < n; j++)
            if (row_width[j] < row_width[pick])
                pick = j;
        sum = row_width[pick] + w + gap;
        row_width[pick] = (sum > ROW_SAT) ? ROW_SAT : sum[ROW_W-1:0];
        top = '0;
        for (int j = 0; j < n; j++)
            if (row_width[j] > top)
                top = row_width[j];
        res.row    = pick[CHOICE_W-1:0];
        res.widest = top;
        res.done   = last;
        if (last)
            refill_rows();
        return res;
    endfunction

    function automatic void check_field(input string name, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s expected %0d got %0d", $time, name, want, got);
            errors++;
        end
    endfunction

    // configuration writes, result comparison, then prediction of new transactions
    always @(posedge clk or negedge rst_n)
    begin
        placement_t want;
        if (!rst_n)
        begin
            row_count = ROW_COUNT_RST;
            gap       = GAP_RST;
            refill_rows();
            placements.delete();
            errors  = 0;
            pending = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == CFG_ROW_COUNT)
                begin
                    row_count = cfg_data[CNT_W-1:0];
                    refill_rows();
                end
                else if (cfg_index == CFG_GAP)
                begin
                    gap = cfg_data[GAP_W-1:0];
                    refill_rows();
                end
            end
            if (out_valid && !out_stall)
            begin
                if (placements.size() == 0)
                begin
                    $display("%0t: result with nothing expected: row %0d widest %0d done %0d",
                             $time, row_choice, widest_row, done_res);
                    errors++;
                end
                else
                begin
                    want = placements.pop_front();
                    check_field("row_choice", want.row, row_choice);
                    check_field("widest_row", want.widest, widest_row);
                    check_field("done_res", want.done, done_res);
                end
            end
            if (in_valid && !in_stall)
                placements.insert(placements.size(), place_item(item_width, is_last));
            pending = placements.size();
        end
    end

endmodule

FILE: sim/greedy_min_width_row_assigner_core_tb.sv
// testbench top for the row assigner: stimulus, output back-pressure and verdict
`timescale 1ns / 1ps

module greedy_min_width_row_assigner_core_tb;
    import gmra_pkg::*;

    // register indexes that the block does not decode
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;
    localparam int QUIET_LIMIT = 1000;
    localparam int ITEM_TARGET = 750;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  in_valid = 1'b0;
    logic [ITEM_W-1:0]     item_width = '0;
    logic                  is_last = 1'b0;
    logic                  out_stall = 1'b0;
    logic                  in_stall;
    logic                  out_valid;
    logic [CHOICE_W-1:0]   row_choice;
    logic [ROW_W-1:0]      widest_row;
    logic                  done_res;
    int                    errors;
    int                    pending;

    bit calm = 1'b0;
    bit hold_req = 1'b0;
    int hold_left = 0;
    int quiet = 0;
    int sent = 0;

    greedy_min_width_row_assigner_core dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .item_width (item_width),
        .is_last    (is_last),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .row_choice (row_choice),
        .widest_row (widest_row),
        .done_res   (done_res)
    );

    gmra_checker chk (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .item_width (item_width),
        .is_last    (is_last),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .row_choice (row_choice),
        .widest_row (widest_row),
        .done_res   (done_res),
        .errors     (errors),
        .pending    (pending)
    );

    always #2 clk = ~clk;

    // output side: random stalls, a calm stretch, and one long hold-off on request
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else if (hold_req)
        begin
            hold_req = 1'b0;
            hold_left = 79;
            out_stall <= 1'b1;
        end
        else
            out_stall <= !calm && ($urandom_range(0, 99) < 37);
    end

    // watchdog on cycles without any transaction
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet = 0;
            else
                quiet++;
            if (quiet >= QUIET_LIMIT)
            begin
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    // one item transaction, with random idle cycles ahead of it
    task automatic send_item(input logic [ITEM_W-1:0] w, input logic last);
        while (!calm && $urandom_range(0, 99) < 37)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid   <= 1'b1;
        item_width <= w;
        is_last    <= last;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
        sent++;
    endtask

    task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
    endtask

    // both registers in random order, optionally a write to an undecoded index
    task automatic configure(input logic [CFG_DATA_W-1:0] rows_data,
                             input logic [CFG_DATA_W-1:0] gap_data, input bit junk);
        if ($urandom_range(0, 1))
        begin
            put_reg(CFG_ROW_COUNT, rows_data);
            put_reg(CFG_GAP, gap_data);
        end
        else
        begin
            put_reg(CFG_GAP, gap_data);
            put_reg(CFG_ROW_COUNT, rows_data);
        end
        if (junk)
            put_reg($urandom_range(0, 1) ? CFG_SPARE_A : CFG_SPARE_B, CFG_DATA_W'($urandom));
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    // let every result drain, then allow the block to settle
    task automatic drain();
        in_valid <= 1'b0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
        repeat (16) @(negedge clk);
    endtask

    function automatic logic [ITEM_W-1:0] pick_width(input bit heavy);
        if (heavy && $urandom_range(0, 3) != 0)
            return '1;
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2, 3, 4: return ITEM_W'($urandom_range(0, 63));
            default: return ITEM_W'($urandom);
        endcase
    endfunction

    initial
    begin
        bit                  heavy;
        int                  set_left;
        int                  phase_items;
        logic [CNT_W-1:0]    rows;
        logic [GAP_W-1:0]    pad;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset registers: one row, no padding
        send_item('0, 1'b0);
        send_item('1, 1'b0);
        send_item(12'd1, 1'b1);
        drain();

        // eight rows with full padding, ties resolve to the lowest row
        configure(8'hF8, 8'hFF, 1'b0);
        send_item('0, 1'b0);
        send_item('0, 1'b0);
        send_item('1, 1'b0);
        send_item(12'd2048, 1'b0);
        send_item('0, 1'b1);
        drain();

        // zero row count acts as one row; widest items drive the row into saturation
        configure(8'h00, 8'hFF, 1'b1);
        for (int i = 0; i < 16; i++)
            send_item('1, i == 15);
        drain();

        // random phases, each with its own register settings
        for (int ph = 0; sent < ITEM_TARGET; ph++)
        begin
            calm  = (ph == 2);
            heavy = (ph == 6) || ($urandom_range(0, 7) == 0);
            case ($urandom_range(0, 5))
                0:       rows = 4'd0;
                1:       rows = 4'd1;
                2:       rows = 4'd8;
                3:       rows = 4'd15;
                default: rows = CNT_W'($urandom_range(0, 15));
            endcase
            if (heavy)
                rows = CNT_W'($urandom_range(0, 2));
            case ($urandom_range(0, 3))
                0:       pad = 8'd0;
                1:       pad = 8'd255;
                default: pad = GAP_W'($urandom);
            endcase
            configure({4'($urandom_range(0, 15)), rows}, pad, $urandom_range(0, 3) == 0);
            phase_items = $urandom_range(60, 100);
            set_left = 0;
            for (int k = 0; k < phase_items; k++)
            begin
                if (ph == 4 && k == 5)
                    hold_req = 1'b1;
                if (set_left == 0)
                    set_left = heavy ? $urandom_range(10, 24) : $urandom_range(1, 12);
                send_item(pick_width(heavy), set_left == 1);
                set_left--;
            end
            drain();
        end
        calm = 1'b0;

        if (errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
